// ===== rtl/tlsd_pkg.sv =====
// Shared constants, request codes and control types of the timed LED driver.
package tlsd_pkg;

  // Fixed widths of the pattern, deadline and stream payloads.
  localparam int PATTERN_W     = 8;
  localparam int SLOT_COUNT    = 8;
  localparam int SLOT_IDX_W    = 3;
  localparam int DEADLINE_W    = 32;
  localparam int LED_COUNT_DEF = 8;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 16;

  localparam logic [DEADLINE_W-1:0] DEADLINE_MAX = 32'hffff_ffff;

  // Request kinds carried on in_tuser.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;

  // Number of LEDs that are actually driven.
  function automatic int active_of(input int led_count);
    return (led_count < SLOT_COUNT) ? led_count : SLOT_COUNT;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  do_set;
    logic                  do_toggle;
    logic                  tick_start;
    logic                  scan_en;
    logic [SLOT_IDX_W-1:0] scan_idx;
    logic                  load_status;
    logic                  load_bit;
    logic [SLOT_IDX_W-1:0] bit_sel;
    logic                  bit_last;
    logic                  shown_update;
  } tlsd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic pattern_changed;
  } tlsd_sts_t;

endpackage

// ===== rtl/tlsd_datapath.sv =====
// Datapath of the timed LED driver: patterns, deadlines, clock and output register.
module tlsd_datapath import tlsd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlsd_cmd_t              cmd,
  input  logic [2:0]             led_index,
  input  logic                   led_on,
  input  logic                   permanent,
  input  logic [DEADLINE_W-1:0]  duration_ms,
  output tlsd_sts_t              sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0 up: serial_bit, led_pattern[7:0], zero fill.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Fields from bit 0 up: bit_valid.
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int ACTIVE = active_of(LED_COUNT);
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

  logic [PATTERN_W-1:0]  pending_r, pending_nxt;
  logic [PATTERN_W-1:0]  shown_r, shown_nxt;
  logic [PATTERN_W-1:0]  timed_r, timed_nxt;
  logic [DEADLINE_W-1:0] clock_r, clock_nxt;
  logic [DEADLINE_W-1:0] deadline_r [ACTIVE];

  logic                  out_valid_r, out_valid_nxt;
  logic                  serial_r, serial_nxt;
  logic                  bitv_r, bitv_nxt;
  logic                  last_r, last_nxt;
  logic [PATTERN_W-1:0]  pattern_r, pattern_nxt;

  logic [PATTERN_W-1:0]  led_mask;
  logic [PATTERN_W-1:0]  scan_mask;
  logic                  index_ok;
  logic [DEADLINE_W:0]   fin_sum;
  logic [DEADLINE_W-1:0] fin;
  logic                  expire;
  logic                  dl_we;
  logic [DEADLINE_W-1:0] dl_data;

  // Request decode helpers and the saturating deadline sum.
  always_comb begin
    led_mask  = PATTERN_W'(1) << led_index;
    scan_mask = PATTERN_W'(1) << cmd.scan_idx;
    index_ok  = ({1'b0, led_index} < 4'(ACTIVE));
    fin_sum   = {1'b0, clock_r} + {1'b0, duration_ms};
    fin       = fin_sum[DEADLINE_W] ? DEADLINE_MAX : fin_sum[DEADLINE_W-1:0];
    expire    = ((timed_r & scan_mask) != '0) &&
                (deadline_r[cmd.scan_idx[IDX_W-1:0]] < clock_r);
  end

  // Next state of the LED state registers.
  always_comb begin
    pending_nxt = pending_r;
    shown_nxt   = shown_r;
    timed_nxt   = timed_r;
    clock_nxt   = clock_r;
    dl_we       = 1'b0;
    dl_data     = '0;
    if (cmd.do_set && index_ok) begin
      if (led_on) begin
        pending_nxt = pending_r & ~led_mask;
      end else begin
        pending_nxt = pending_r | led_mask;
      end
      dl_we = 1'b1;
      if (permanent) begin
        timed_nxt = timed_r & ~led_mask;
        dl_data   = '0;
      end else begin
        timed_nxt = timed_r | led_mask;
        dl_data   = fin;
      end
    end
    if (cmd.do_toggle && index_ok) begin
      pending_nxt = pending_r ^ led_mask;
      timed_nxt   = timed_r & ~led_mask;
      dl_we       = 1'b1;
      dl_data     = '0;
    end
    if (cmd.tick_start) begin
      clock_nxt = clock_r + DEADLINE_W'(1);
    end
    if (cmd.scan_en && expire) begin
      timed_nxt   = timed_r & ~scan_mask;
      pending_nxt = pending_r | scan_mask;
    end
    if (cmd.shown_update) begin
      shown_nxt = pending_r;
    end
  end

  // Output register: loaded only when free, cleared on a completed transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    serial_nxt    = serial_r;
    bitv_nxt      = bitv_r;
    last_nxt      = last_r;
    pattern_nxt   = pattern_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_status) begin
      out_valid_nxt = 1'b1;
      serial_nxt    = 1'b0;
      bitv_nxt      = 1'b0;
      last_nxt      = 1'b0;
      pattern_nxt   = pending_r;
    end
    if (cmd.load_bit) begin
      out_valid_nxt = 1'b1;
      serial_nxt    = pending_r[cmd.bit_sel];
      bitv_nxt      = 1'b1;
      last_nxt      = cmd.bit_last;
      pattern_nxt   = pending_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '1;
      shown_r     <= '0;
      timed_r     <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      shown_r     <= shown_nxt;
      timed_r     <= timed_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers and deadline slots; a deadline is read only while timed.
  always_ff @(posedge clk) begin
    serial_r  <= serial_nxt;
    bitv_r    <= bitv_nxt;
    last_r    <= last_nxt;
    pattern_r <= pattern_nxt;
    if (dl_we) begin
      deadline_r[led_index[IDX_W-1:0]] <= dl_data;
    end
  end

  assign sts.out_free        = !out_valid_r || out_tready;
  assign sts.pattern_changed = (pending_r != shown_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - PATTERN_W - 1){1'b0}}, pattern_r, serial_r};
  assign out_tuser  = bitv_r;
  assign out_tlast  = last_r;

endmodule

// ===== rtl/tlsd_ctrl.sv =====
// Controller of the timed LED driver: request decode, expiry scan and shift sequencing.
module tlsd_ctrl import tlsd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] req_type,
  input  tlsd_sts_t  sts,
  output tlsd_cmd_t  cmd
);

  localparam int ACTIVE = active_of(LED_COUNT);
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(ACTIVE - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_STATUS
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             ready_r, ready_nxt;
  logic             accept;
  logic             cnt_at_last;

  assign accept      = in_tvalid && ready_r;
  assign cnt_at_last = (cnt_r == CNT_LAST);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ready_nxt = ready_r;
    cmd       = '0;
    cmd.scan_idx = SLOT_IDX_W'(cnt_r);
    cmd.bit_sel  = SLOT_IDX_W'(7) - SLOT_IDX_W'(cnt_r);
    cmd.bit_last = cnt_at_last;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ready_nxt = 1'b0;
          cnt_nxt   = '0;
          case (req_type)
            REQ_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            REQ_SET: begin
              cmd.do_set = 1'b1;
              state_nxt  = ST_STATUS;
            end
            REQ_TOGGLE: begin
              cmd.do_toggle = 1'b1;
              state_nxt     = ST_STATUS;
            end
            default: begin
              state_nxt = ST_STATUS;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // One LED deadline is checked per cycle.
        cmd.scan_en = 1'b1;
        if (cnt_at_last) begin
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DECIDE: begin
        cnt_nxt = '0;
        if (sts.pattern_changed) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_STATUS;
        end
      end
      ST_SHIFT: begin
        // One serial bit per free output slot, MSB first.
        if (sts.out_free) begin
          cmd.load_bit = 1'b1;
          if (cnt_at_last) begin
            cmd.shown_update = 1'b1;
            state_nxt        = ST_IDLE;
            ready_nxt        = 1'b1;
          end else begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end
      end
      ST_STATUS: begin
        if (sts.out_free) begin
          cmd.load_status = 1'b1;
          state_nxt       = ST_IDLE;
          ready_nxt       = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ready_nxt = 1'b1;
      end
    endcase
  end

  // State, counter and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ready_r <= ready_nxt;
    end
  end

  assign in_tready = ready_r;

endmodule

// ===== rtl/timed_led_shift_register_driver.sv =====
// A set or toggle is taken in ST_IDLE; ST_STATUS then loads its status result into the output register.
// A tick scans one LED deadline per cycle over N = min(LED_COUNT, 8) LEDs, then decides: if the
// pattern changed it offers N serial bits at one per cycle while the output register is free,
// else a status result. The input is not ready again until the request is finished.
// Reset (synchronous, rst_n low): all LEDs off pending, shown pattern zero, no timed LEDs,
// clock zero, output empty, input ready.
module timed_led_shift_register_driver import tlsd_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0 up: led_index[2:0], led_on, permanent, duration_ms[31:0], zero fill.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0 up: req_type[1:0].
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0 up: serial_bit, led_pattern[7:0], zero fill.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Fields from bit 0 up: bit_valid.
  output logic                   out_tuser,
  output logic                   out_tlast
);

  tlsd_cmd_t cmd;
  tlsd_sts_t sts;

  tlsd_ctrl #(
    .LED_COUNT (LED_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req_type  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlsd_datapath #(
    .LED_COUNT (LED_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .led_index   (in_tdata[2:0]),
    .led_on      (in_tdata[3]),
    .permanent   (in_tdata[4]),
    .duration_ms (in_tdata[36:5]),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
